// ===== hw/rtl/assert_macros.svh =====
// assertion macros, clocked on the rising edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, always on
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/oqkd_pkg.sv =====
package oqkd_pkg;

  localparam int RUN_BITS   = 8;
  localparam int COUNT_BITS = 8;

  localparam int CFG_BITS   = 8;
  localparam int CFG_IDX_BITS = 2;
  localparam int SAMPLE_BITS = 8;
  localparam int STEP_BITS  = 2;
  localparam int TOTAL_BITS = 8;
  localparam int OUT_DATA_BITS = 16;
  localparam int OUT_PAD_BITS = OUT_DATA_BITS - STEP_BITS - TOTAL_BITS;

  localparam int CMP_BITS = (RUN_BITS > CFG_BITS) ? RUN_BITS : CFG_BITS;
  localparam int TOTAL_EXT_BITS = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_RUN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_RUN_LENGTH  = 2'd2;

  localparam logic [CFG_BITS-1:0] RST_LEVEL_THRESHOLD = 8'd100;
  localparam logic [CFG_BITS-1:0] RST_HIGH_RUN_LENGTH = 8'd10;
  localparam logic [CFG_BITS-1:0] RST_LOW_RUN_LENGTH  = 8'd40;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] QUAD_IDLE = 2'd0;
  localparam logic [1:0] QUAD_A    = 2'd1;
  localparam logic [1:0] QUAD_B    = 2'd2;
  localparam logic [1:0] QUAD_BOTH = 2'd3;

  localparam logic signed [STEP_BITS-1:0] DIR_NONE = 2'sb00;
  localparam logic signed [STEP_BITS-1:0] DIR_CCW  = 2'sb11;
  localparam logic signed [STEP_BITS-1:0] DIR_CW   = 2'sb01;

  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};
  localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

endpackage

// ===== hw/rtl/optical_quadrature_knob_decoder.sv =====
// an accepted input passes through the input register, then the result register, to out_tvalid
// throughput: one item per cycle; the input side stalls only while a result waits
// in the result register and out_tready is low
// reset (rst_n low, synchronous): both stages empty, run counters, levels, detent
// machine and turn count cleared, registers back to 100 / 10 / 40
module optical_quadrature_knob_decoder
  import oqkd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // sample_value
  input  logic [1:0]               in_tuser,   // op, sensor_channel
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata   // step[1:0], turn_total[9:2], zero pad
);

  logic [CFG_BITS-1:0] thr_r, high_len_r, low_len_r;

  logic                   s1_valid_r;
  logic                   s1_op_r;
  logic                   s1_ch_r;
  logic [SAMPLE_BITS-1:0] s1_value_r;

  logic                        last_raw_r [2];
  logic [RUN_BITS-1:0]         run_r      [2];
  logic                        qual_r     [2];
  logic [1:0]                  last_quad_r;
  logic                        armed_r;
  logic signed [STEP_BITS-1:0] dir_r;
  logic signed [COUNT_BITS-1:0] count_r;

  logic                         out_valid_r;
  logic [OUT_DATA_BITS-1:0]     out_data_r;

  logic out_free, s1_fire;

  logic                         raw;
  logic [RUN_BITS-1:0]          run_nxt;
  logic                         qual_nxt;
  logic                         qual_a, qual_b;
  logic [1:0]                   quad;
  logic                         armed_nxt;
  logic signed [STEP_BITS-1:0]  dir_nxt;
  logic signed [STEP_BITS-1:0]  step;
  logic signed [COUNT_BITS-1:0] count_nxt;
  logic signed [COUNT_BITS-1:0] total_src;
  logic signed [TOTAL_EXT_BITS-1:0] total_ext;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;
  assign s1_fire   = s1_valid_r && out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= RST_LEVEL_THRESHOLD;
      high_len_r <= RST_HIGH_RUN_LENGTH;
      low_len_r  <= RST_LOW_RUN_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL_THRESHOLD: thr_r      <= cfg_wdata;
        REG_HIGH_RUN_LENGTH: high_len_r <= cfg_wdata;
        REG_LOW_RUN_LENGTH:  low_len_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r    <= in_tuser[0];
      s1_ch_r    <= in_tuser[1];
      s1_value_r <= in_tdata;
    end
  end

  // channel qualification
  always_comb begin
    raw = s1_value_r > thr_r;
    if (last_raw_r[s1_ch_r] != raw) begin
      run_nxt = '0;
    end else if (run_r[s1_ch_r] != RUN_MAX) begin
      run_nxt = run_r[s1_ch_r] + RUN_BITS'(1);
    end else begin
      run_nxt = run_r[s1_ch_r];
    end
    qual_nxt = qual_r[s1_ch_r];
    if (raw && (CMP_BITS'(run_nxt) > CMP_BITS'(high_len_r))) begin
      qual_nxt = 1'b1;
    end else if (!raw && (CMP_BITS'(run_nxt) > CMP_BITS'(low_len_r))) begin
      qual_nxt = 1'b0;
    end
    qual_a = s1_ch_r ? qual_r[0] : qual_nxt;
    qual_b = s1_ch_r ? qual_nxt : qual_r[1];
    quad   = {qual_b, qual_a};
  end

  // detent machine
  always_comb begin
    armed_nxt = armed_r;
    dir_nxt   = dir_r;
    step      = DIR_NONE;
    if (quad != last_quad_r) begin
      case (quad)
        QUAD_IDLE: begin
          if (armed_r) begin
            armed_nxt = 1'b0;
            step      = dir_r;
          end
        end
        QUAD_A: begin
          if (!armed_r) begin
            dir_nxt = DIR_CCW;
          end else if (dir_r != DIR_CW) begin
            armed_nxt = 1'b0;
          end
        end
        QUAD_B: begin
          if (!armed_r) begin
            dir_nxt = DIR_CW;
          end else if (dir_r != DIR_CCW) begin
            armed_nxt = 1'b0;
          end
        end
        default: armed_nxt = 1'b1;
      endcase
    end
  end

  // turn count
  always_comb begin
    count_nxt = count_r;
    if (step == DIR_CW && count_r != COUNT_MAX) begin
      count_nxt = count_r + COUNT_BITS'(1);
    end else if (step == DIR_CCW && count_r != COUNT_MIN) begin
      count_nxt = count_r - COUNT_BITS'(1);
    end
    total_src = (s1_op_r == OP_READ) ? count_r : count_nxt;
    total_ext = TOTAL_EXT_BITS'(total_src);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r[0] <= 1'b0;
      last_raw_r[1] <= 1'b0;
      run_r[0]      <= '0;
      run_r[1]      <= '0;
      qual_r[0]     <= 1'b0;
      qual_r[1]     <= 1'b0;
      last_quad_r   <= QUAD_IDLE;
      armed_r       <= 1'b0;
      dir_r         <= DIR_NONE;
      count_r       <= '0;
    end else if (s1_fire) begin
      if (s1_op_r == OP_READ) begin
        count_r <= '0;
      end else begin
        last_raw_r[s1_ch_r] <= raw;
        run_r[s1_ch_r]      <= run_nxt;
        qual_r[s1_ch_r]     <= qual_nxt;
        last_quad_r         <= quad;
        armed_r             <= armed_nxt;
        dir_r               <= dir_nxt;
        count_r             <= count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {{OUT_PAD_BITS{1'b0}}, total_ext[TOTAL_BITS-1:0],
                     (s1_op_r == OP_READ) ? DIR_NONE : step};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/oqkd_checker.sv =====
`include "assert_macros.svh"

module oqkd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_tready, out_tvalid && !out_tready)
  `ASSERT_IMPL(a_step_code, clk, rst_n, out_tvalid, out_tdata[1:0] != 2'b10)

endmodule

bind optical_quadrature_knob_decoder oqkd_checker u_oqkd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
